### sv/ffha_pkg.sv
// Shared types, constants and helpers of the first-fit heap allocator.
package ffha_pkg;

   localparam int AW = 20;
   localparam int BW = 21;
   localparam int PAGE_SHIFT = 12;
   localparam int MAX_PAGES = 256;

   localparam logic        CMD_ALLOC = 1'b0;
   localparam logic        CMD_FREE  = 1'b1;

   localparam logic [7:0]  REG_HEAP_BASE     = 8'd0;
   localparam logic [7:0]  REG_INITIAL_PAGES = 8'd1;
   localparam logic [7:0]  REG_GROW_PAGES    = 8'd2;
   localparam logic [7:0]  REG_MAX_PAGES     = 8'd3;

   localparam logic [31:0] HEAP_BASE_RST  = 32'hD000_0000;
   localparam logic [8:0]  INIT_PAGES_RST = 9'd16;
   localparam logic [8:0]  GROW_PAGES_RST = 9'd8;
   localparam logic [8:0]  MAX_PAGES_RST  = 9'd256;

   localparam logic [31:0] SIZE_LIMIT = 32'h7FFF_FFFF;
   localparam logic [31:0] ALIGN_MASK = 32'h0000_0007;
   localparam logic [31:0] HDR_WORD   = 32'd16;
   localparam logic [31:0] SPLIT_MIN  = 32'd24;
   localparam logic [AW-1:0] HDR_SZ   = AW'(16);
   localparam logic [AW-1:0] PAGE_SZ  = AW'(4096);
   localparam logic [AW-1:0] FRESH_SZ = AW'(4080);

   typedef struct packed {
      logic [AW-1:0] off;
      logic [AW-1:0] sz;
      logic          fr;
   } entry_type;

   typedef struct packed {
      logic          vld;
      logic          hit;
      logic [AW-1:0] hit_off;
      logic [AW-1:0] hit_sz;
      logic          hit_fr;
      logic          prv_fr;
      logic [AW-1:0] prv_off;
      logic [AW-1:0] prv_sz;
      logic          nxt_seen;
      logic          nxt_fr;
      logic [AW-1:0] nxt_sz;
      logic [AW-1:0] last_off;
      logic [AW-1:0] last_sz;
      logic          last_fr;
   } scan_type;

   typedef struct packed {
      logic          mode_free;
      logic [31:0]   want;
      logic [31:0]   arel;
      entry_type     wdata;
   } bcast_type;

   function automatic logic [8:0] clamp_pages(input logic [8:0] v);
      logic [8:0] r;
      r = v;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if (v > 9'(MAX_PAGES)) begin
         r = 9'(MAX_PAGES);
      end
      return r;
   endfunction

   function automatic logic [BW-1:0] page_bytes(input logic [8:0] p);
      return {p, {PAGE_SHIFT{1'b0}}};
   endfunction

endpackage

### sv/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator: cell row and command sequencer.
//
// Command channel: drive start high with req_command, req_alloc_size and
// req_free_address; the word is taken at an edge where busy is low. busy
// stays high until the result strobe. csr_* writes heap_base, initial_pages,
// grow_pages and max_pages by index; csr_ready is high while idle with start
// low, and a write of initial_pages rebuilds the heap as one free block,
// holding busy for one cycle.
// Each command yields one result word, shown on rsp_* for one cycle with
// rsp_valid high; the receiver takes it at once and cannot stall.
// Sequence: a bad allocate size goes straight to the result. Otherwise a scan
// word is launched along the row of MAX_BLOCKS cells, registered in each cell,
// and is then evaluated; an allocate that splits or a free that merges into
// the previous block passes through S_OP2 before the result. An allocate
// that finds no fit adds one page a cycle (up to grow_pages) and scans
// again, until a block fits or growth fails.
// One command at a time: a new word is taken only after the result is shown.
// Reset: synchronous, active high; the state, heap and CSR registers take
// their reset values, and the heap is then rebuilt before start is taken.
module first_fit_heap_allocator_top #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [31:0] req_alloc_size,
   input  logic [31:0] req_free_address,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [31:0] rsp_address,
   output logic [20:0] rsp_total_bytes,
   output logic [20:0] rsp_used_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AW = ffha_pkg::AW;
   localparam int BW = ffha_pkg::BW;

   localparam logic [2:0] S_INIT = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_EVAL = 3'd3;
   localparam logic [2:0] S_OP2  = 3'd4;
   localparam logic [2:0] S_GROW = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;
   localparam logic [2:0] S_LOAD = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic [31:0]         want_ff, want_in;
   logic [31:0]         arel_ff, arel_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [8:0]          pages_ff, pages_in;
   logic [BW-1:0]       used_ff, used_in;
   logic [31:0]         base_ff, base_in;
   logic [8:0]          initp_ff, initp_in;
   logic [8:0]          growp_ff, growp_in;
   logic [8:0]          maxp_ff, maxp_in;
   ffha_pkg::scan_type  sr_ff, sr_in;
   logic [IW-1:0]       sidx_ff, sidx_in;
   ffha_pkg::entry_type tail_ff, tail_in;
   logic [8:0]          k_ff, k_in;
   logic [AW-1:0]       msz_ff, msz_in;
   logic                st_ff, st_in;
   logic [31:0]         addr_ff, addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_status_ff;
   logic [31:0]         rsp_address_ff;
   logic [20:0]         rsp_total_ff;
   logic [20:0]         rsp_used_ff;

   logic                op_wr, op_up, op_dn, inject;
   logic [IW-1:0]       op_widx, op_from;
   ffha_pkg::entry_type op_wdata;
   ffha_pkg::bcast_type bc;
   logic [8:0]          p_init, n_grow, lim;
   logic [AW-1:0]       new_sz;
   logic                csr_fire;

   ffha_pkg::entry_type ent   [MAX_BLOCKS];
   ffha_pkg::scan_type  rec   [MAX_BLOCKS+1];
   logic [IW-1:0]       rpos  [MAX_BLOCKS+1];
   logic [IW-1:0]       ridx  [MAX_BLOCKS+1];
   logic [MAX_BLOCKS-1:0] wr_sel, up_sel, dn_sel, live;

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE) && !start;
   assign csr_fire  = csr_valid && csr_ready;
   assign p_init    = ffha_pkg::clamp_pages(initp_ff);
   assign n_grow    = ffha_pkg::clamp_pages(growp_ff);
   assign lim       = ffha_pkg::clamp_pages(maxp_ff);

   always_comb begin
      bc.mode_free = cmd_ff;
      bc.want      = want_ff;
      bc.arel      = arel_ff;
      bc.wdata     = op_wdata;
   end

   assign rec[0]  = '{vld: inject, default: '0};
   assign rpos[0] = '0;
   assign ridx[0] = '0;

   genvar g;
   generate
      for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
         assign wr_sel[g] = op_wr && (op_widx == IW'(g));
         assign up_sel[g] = op_up && (IW'(g) > op_from);
         assign dn_sel[g] = op_dn && (IW'(g) >= op_from);
         assign live[g]   = (CW'(g) < count_ff);
         ffha_cell #(.IW(IW)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .bc       (bc),
            .wr       (wr_sel[g]),
            .up       (up_sel[g]),
            .dn       (dn_sel[g]),
            .live     (live[g]),
            .left     (ent[(g > 0) ? g - 1 : 0]),
            .right    (ent[(g < MAX_BLOCKS - 1) ? g + 1 : MAX_BLOCKS - 1]),
            .ent      (ent[g]),
            .rin      (rec[g]),
            .rin_pos  (rpos[g]),
            .rin_idx  (ridx[g]),
            .rout     (rec[g+1]),
            .rout_pos (rpos[g+1]),
            .rout_idx (ridx[g+1])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      want_in      = want_ff;
      arel_in      = arel_ff;
      count_in     = count_ff;
      pages_in     = pages_ff;
      used_in      = used_ff;
      base_in      = base_ff;
      initp_in     = initp_ff;
      growp_in     = growp_ff;
      maxp_in      = maxp_ff;
      sr_in        = sr_ff;
      sidx_in      = sidx_ff;
      tail_in      = tail_ff;
      k_in         = k_ff;
      msz_in       = msz_ff;
      st_in        = st_ff;
      addr_in      = addr_ff;
      rsp_valid_in = 1'b0;
      op_wr        = 1'b0;
      op_up        = 1'b0;
      op_dn        = 1'b0;
      op_widx      = '0;
      op_from      = '0;
      op_wdata     = '0;
      inject       = 1'b0;
      new_sz       = sr_ff.hit_sz;

      case (state_ff)
         S_INIT: begin
            op_wr        = 1'b1;
            op_wdata.off = '0;
            op_wdata.sz  = AW'(ffha_pkg::page_bytes(p_init) - BW'(16));
            op_wdata.fr  = 1'b1;
            count_in     = CW'(1);
            pages_in     = p_init;
            used_in      = '0;
            state_in     = S_IDLE;
         end
         S_IDLE: begin
            if (csr_fire) begin
               case (csr_index)
                  ffha_pkg::REG_HEAP_BASE: base_in = csr_wdata;
                  ffha_pkg::REG_INITIAL_PAGES: begin
                     initp_in = csr_wdata[8:0];
                     state_in = S_INIT;
                  end
                  ffha_pkg::REG_GROW_PAGES: growp_in = csr_wdata[8:0];
                  ffha_pkg::REG_MAX_PAGES: maxp_in = csr_wdata[8:0];
                  default: ;
               endcase
            end else if (start) begin
               cmd_in  = req_command;
               want_in = (req_alloc_size + ffha_pkg::ALIGN_MASK) & ~ffha_pkg::ALIGN_MASK;
               arel_in = req_free_address - base_ff - ffha_pkg::HDR_WORD;
               addr_in = '0;
               if (req_command == ffha_pkg::CMD_ALLOC &&
                   (req_alloc_size == 32'd0 || req_alloc_size > ffha_pkg::SIZE_LIMIT)) begin
                  st_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  state_in = S_LOAD;
               end
            end
         end
         S_LOAD: begin
            inject   = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (rec[MAX_BLOCKS].vld) begin
               sr_in    = rec[MAX_BLOCKS];
               sidx_in  = ridx[MAX_BLOCKS];
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            op_widx = sidx_ff;
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               if (sr_ff.hit) begin
                  op_wr        = 1'b1;
                  op_wdata.off = sr_ff.hit_off;
                  op_wdata.fr  = 1'b0;
                  st_in        = 1'b0;
                  addr_in      = base_ff + 32'(sr_ff.hit_off) + ffha_pkg::HDR_WORD;
                  if (32'(sr_ff.hit_sz) > want_ff + ffha_pkg::SPLIT_MIN &&
                      count_ff < CW'(MAX_BLOCKS)) begin
                     op_wdata.sz = want_ff[AW-1:0];
                     used_in     = used_ff + BW'(want_ff[AW-1:0]);
                     state_in    = S_OP2;
                  end else begin
                     op_wdata.sz = sr_ff.hit_sz;
                     used_in     = used_ff + BW'(sr_ff.hit_sz);
                     state_in    = S_DONE;
                  end
               end else begin
                  k_in        = '0;
                  tail_in.off = sr_ff.last_off;
                  tail_in.sz  = sr_ff.last_sz;
                  tail_in.fr  = sr_ff.last_fr;
                  state_in    = S_GROW;
               end
            end else begin
               addr_in = '0;
               if (!sr_ff.hit || sr_ff.hit_fr) begin
                  st_in    = 1'b1;
                  state_in = S_DONE;
               end else begin
                  st_in = 1'b0;
                  if (used_ff >= BW'(sr_ff.hit_sz)) begin
                     used_in = used_ff - BW'(sr_ff.hit_sz);
                  end else begin
                     used_in = '0;
                  end
                  if (sr_ff.nxt_seen && sr_ff.nxt_fr) begin
                     new_sz   = sr_ff.hit_sz + ffha_pkg::HDR_SZ + sr_ff.nxt_sz;
                     op_dn    = 1'b1;
                     op_from  = sidx_ff + IW'(1);
                     count_in = count_ff - CW'(1);
                  end
                  op_wr        = 1'b1;
                  op_wdata.off = sr_ff.hit_off;
                  op_wdata.sz  = new_sz;
                  op_wdata.fr  = 1'b1;
                  msz_in       = new_sz;
                  state_in     = sr_ff.prv_fr ? S_OP2 : S_DONE;
               end
            end
         end
         S_OP2: begin
            op_wr       = 1'b1;
            op_wdata.fr = 1'b1;
            if (cmd_ff == ffha_pkg::CMD_ALLOC) begin
               op_widx      = sidx_ff + IW'(1);
               op_wdata.off = sr_ff.hit_off + ffha_pkg::HDR_SZ + want_ff[AW-1:0];
               op_wdata.sz  = sr_ff.hit_sz - want_ff[AW-1:0] - ffha_pkg::HDR_SZ;
               op_up        = 1'b1;
               op_from      = sidx_ff + IW'(1);
               count_in     = count_ff + CW'(1);
            end else begin
               op_widx      = sidx_ff - IW'(1);
               op_wdata.off = sr_ff.prv_off;
               op_wdata.sz  = sr_ff.prv_sz + ffha_pkg::HDR_SZ + msz_ff;
               op_dn        = 1'b1;
               op_from      = sidx_ff;
               count_in     = count_ff - CW'(1);
            end
            state_in = S_DONE;
         end
         S_GROW: begin
            if (k_ff == n_grow) begin
               inject   = 1'b1;
               state_in = S_SCAN;
            end else if (pages_ff >= lim) begin
               st_in    = 1'b1;
               addr_in  = '0;
               state_in = S_DONE;
            end else if (tail_ff.fr) begin
               op_wr        = 1'b1;
               op_widx      = IW'(count_ff - CW'(1));
               op_wdata.off = tail_ff.off;
               op_wdata.sz  = tail_ff.sz + ffha_pkg::PAGE_SZ;
               op_wdata.fr  = 1'b1;
               tail_in.sz   = tail_ff.sz + ffha_pkg::PAGE_SZ;
               pages_in     = pages_ff + 9'd1;
               k_in         = k_ff + 9'd1;
            end else if (count_ff >= CW'(MAX_BLOCKS)) begin
               st_in    = 1'b1;
               addr_in  = '0;
               state_in = S_DONE;
            end else begin
               op_wr        = 1'b1;
               op_widx      = IW'(count_ff);
               op_wdata.off = tail_ff.off + ffha_pkg::HDR_SZ + tail_ff.sz;
               op_wdata.sz  = ffha_pkg::FRESH_SZ;
               op_wdata.fr  = 1'b1;
               tail_in      = op_wdata;
               count_in     = count_ff + CW'(1);
               pages_in     = pages_ff + 9'd1;
               k_in         = k_ff + 9'd1;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CW'(1);
         pages_ff     <= ffha_pkg::INIT_PAGES_RST;
         used_ff      <= '0;
         base_ff      <= ffha_pkg::HEAP_BASE_RST;
         initp_ff     <= ffha_pkg::INIT_PAGES_RST;
         growp_ff     <= ffha_pkg::GROW_PAGES_RST;
         maxp_ff      <= ffha_pkg::MAX_PAGES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pages_ff     <= pages_in;
         used_ff      <= used_in;
         base_ff      <= base_in;
         initp_ff     <= initp_in;
         growp_ff     <= growp_in;
         maxp_ff      <= maxp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      want_ff <= want_in;
      arel_ff <= arel_in;
      sr_ff   <= sr_in;
      sidx_ff <= sidx_in;
      tail_ff <= tail_in;
      k_ff    <= k_in;
      msz_ff  <= msz_in;
      st_ff   <= st_in;
      addr_ff <= addr_in;
      if (state_ff == S_DONE) begin
         rsp_status_ff  <= st_ff;
         rsp_address_ff <= addr_ff;
         rsp_total_ff   <= 21'(ffha_pkg::page_bytes(pages_ff));
         rsp_used_ff    <= 21'(used_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_address     = rsp_address_ff;
   assign rsp_total_bytes = rsp_total_ff;
   assign rsp_used_bytes  = rsp_used_ff;

endmodule

### sv/ffha_cell.sv
// One cell of the block table: holds an entry, shifts it, and forwards the scan word.
module ffha_cell #(
   parameter int IW = 6
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ffha_pkg::bcast_type  bc,
   input  logic                 wr,
   input  logic                 up,
   input  logic                 dn,
   input  logic                 live,
   input  ffha_pkg::entry_type  left,
   input  ffha_pkg::entry_type  right,
   output ffha_pkg::entry_type  ent,
   input  ffha_pkg::scan_type   rin,
   input  logic [IW-1:0]        rin_pos,
   input  logic [IW-1:0]        rin_idx,
   output ffha_pkg::scan_type   rout,
   output logic [IW-1:0]        rout_pos,
   output logic [IW-1:0]        rout_idx
);

   ffha_pkg::entry_type ent_ff, ent_in;
   ffha_pkg::scan_type  rec_ff, rec_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                match;

   always_comb begin
      ent_in = ent_ff;
      if (wr) begin
         ent_in = bc.wdata;
      end else if (up) begin
         ent_in = left;
      end else if (dn) begin
         ent_in = right;
      end
   end

   always_comb begin
      rec_in = rin;
      pos_in = rin_pos + IW'(1);
      idx_in = rin_idx;
      if (bc.mode_free) begin
         match = (32'(ent_ff.off) == bc.arel);
      end else begin
         match = ent_ff.fr && (32'(ent_ff.sz) >= bc.want);
      end
      if (rin.vld && live) begin
         if (!rin.hit) begin
            if (match) begin
               rec_in.hit     = 1'b1;
               rec_in.hit_off = ent_ff.off;
               rec_in.hit_sz  = ent_ff.sz;
               rec_in.hit_fr  = ent_ff.fr;
               rec_in.prv_fr  = rin.last_fr;
               rec_in.prv_off = rin.last_off;
               rec_in.prv_sz  = rin.last_sz;
               idx_in         = rin_pos;
            end
         end else if (!rin.nxt_seen) begin
            rec_in.nxt_seen = 1'b1;
            rec_in.nxt_fr   = ent_ff.fr;
            rec_in.nxt_sz   = ent_ff.sz;
         end
         rec_in.last_off = ent_ff.off;
         rec_in.last_sz  = ent_ff.sz;
         rec_in.last_fr  = ent_ff.fr;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign ent      = ent_ff;
   assign rout     = rec_ff;
   assign rout_pos = pos_ff;
   assign rout_idx = idx_ff;

endmodule

### sv/ffha_checker.sv
// Port-level checks of the first-fit heap allocator, bound to its top level.
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_status,
   input logic [31:0] rsp_address,
   input logic [20:0] rsp_total_bytes,
   input logic [20:0] rsp_used_bytes
);

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");

   a_idle_at_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while still busy");

   a_fail_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_address == 32'd0)
      else $error("failed word carries an address");

   a_used_within_total: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_used_bytes <= rsp_total_bytes)
      else $error("used bytes exceed arena size");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_address     (rsp_address),
   .rsp_total_bytes (rsp_total_bytes),
   .rsp_used_bytes  (rsp_used_bytes)
);
